[rtl/core/rlas_pkg.sv]
package rlas_pkg;

	// field widths
	localparam int PIX_W      = 8;
	localparam int FRAC_W     = 9;
	localparam int ANGLE_W    = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// angle samples per disc; later lines of a disc are dropped
	localparam int SAMPLES_PER_TURN = 1440;
	// pixels per line that enter the dark fraction
	localparam int MAX_LINE_PIXELS  = 256;
	localparam int CNT_W            = $clog2(MAX_LINE_PIXELS + 1);

	// thresholds are Q8 fractions
	localparam int FRAC_Q = 8;
	localparam int LHS_W  = CNT_W + FRAC_Q;
	localparam int PROD_W = FRAC_W + CNT_W;

	// line event queue between classifier and segmenter
	localparam int EVQ_DEPTH = 4;
	localparam int EVQ_AW    = $clog2(EVQ_DEPTH);

	// register reset values
	localparam logic [PIX_W-1:0]   DARK_LEVEL_RST = PIX_W'(128);
	localparam logic [FRAC_W-1:0]  STANDBY_RST    = FRAC_W'(64);
	localparam logic [FRAC_W-1:0]  WORK_RST       = FRAC_W'(128);
	localparam logic [FRAC_W-1:0]  DRIVE_RST      = FRAC_W'(192);
	localparam logic [ANGLE_W-1:0] SHORT_RUN_RST  = ANGLE_W'(3);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DARK_LEVEL,
		REG_STANDBY_FRACTION,
		REG_WORK_FRACTION,
		REG_DRIVE_FRACTION,
		REG_SHORT_RUN_LIMIT
	} rlas_reg_t;

	typedef enum logic [1:0] {
		CLS_REST,
		CLS_STANDBY,
		CLS_WORK,
		CLS_DRIVE
	} rlas_cls_t;

	typedef struct packed {
		logic [PIX_W-1:0]   dark_level;
		logic [FRAC_W-1:0]  standby_fraction;
		logic [FRAC_W-1:0]  work_fraction;
		logic [FRAC_W-1:0]  drive_fraction;
		logic [ANGLE_W-1:0] short_run_limit;
	} rlas_cfg_t;

	// one classified line
	typedef struct packed {
		rlas_cls_t cls;
		logic      disc;
	} rlas_evt_t;

	// one emitted segment
	typedef struct packed {
		rlas_cls_t          activity_class;
		logic [ANGLE_W-1:0] start_sample;
		logic [ANGLE_W-1:0] end_sample;
		logic [ANGLE_W-1:0] duration;
		logic               last_segment;
	} rlas_seg_t;

endpackage

[rtl/core/rlas_pix_if.sv]
interface rlas_pix_if;
	logic                       valid;
	logic                       ready;
	logic [rlas_pkg::PIX_W-1:0] pixel;
	logic                       line_end;
	logic                       disc_end;

	modport source (output valid, pixel, line_end, disc_end, input ready);
	modport sink (input valid, pixel, line_end, disc_end, output ready);
endinterface

[rtl/core/rlas_seg_if.sv]
interface rlas_seg_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   activity_class;
	logic [rlas_pkg::ANGLE_W-1:0] start_sample;
	logic [rlas_pkg::ANGLE_W-1:0] end_sample;
	logic [rlas_pkg::ANGLE_W-1:0] duration;
	logic                         last_segment;

	modport source (output valid, activity_class, start_sample, end_sample, duration,
		last_segment, input ready);
	modport sink (input valid, activity_class, start_sample, end_sample, duration,
		last_segment, output ready);
endinterface

[rtl/core/rlas_front.sv]
module rlas_front (
	input  logic                clk,
	input  logic                arst_n,
	input  rlas_pkg::rlas_cfg_t cfg,
	rlas_pix_if.sink            pix,
	output logic                ev_valid,
	input  logic                ev_ready,
	output rlas_pkg::rlas_evt_t ev_data
);

	localparam int CW = rlas_pkg::CNT_W;
	localparam int LW = rlas_pkg::LHS_W;
	localparam int PW = rlas_pkg::PROD_W;

	// line counters
	logic [CW-1:0] dark_cnt_q;
	logic [CW-1:0] total_q;
	logic          seen_q;

	// stage 1: fraction of a finished line
	logic          v_s1;
	logic [CW-1:0] num_s1;
	logic [CW-1:0] den_s1;
	logic          disc_s1;

	// stage 2: cross products
	logic          v_s2;
	logic [LW-1:0] lhs_s2;
	logic [PW-1:0] p_standby_s2;
	logic [PW-1:0] p_work_s2;
	logic [PW-1:0] p_drive_s2;
	logic          disc_s2;

	logic          adv1, adv2, acc, line, room, hit, seen_n;
	logic [CW-1:0] dark_cnt_n, total_n;

	// stall chain
	assign adv2      = !v_s2 || ev_ready;
	assign adv1      = !v_s1 || adv2;
	assign pix.ready = adv1;
	assign acc       = pix.valid && pix.ready;
	assign line      = pix.line_end || pix.disc_end;

	// pixel counting, capped at the line length limit
	assign room       = total_q < CW'(rlas_pkg::MAX_LINE_PIXELS);
	assign hit        = room && (pix.pixel < cfg.dark_level);
	assign seen_n     = seen_q || hit;
	assign dark_cnt_n = dark_cnt_q + CW'(hit);
	assign total_n    = total_q + CW'(room && seen_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_cnt_q <= '0;
			total_q    <= '0;
			seen_q     <= 1'b0;
		end else if (acc) begin
			if (line) begin
				dark_cnt_q <= '0;
				total_q    <= '0;
				seen_q     <= 1'b0;
			end else begin
				dark_cnt_q <= dark_cnt_n;
				total_q    <= total_n;
				seen_q     <= seen_n;
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= acc && line;
		end
	end

	// stage 1 payload: no dark pixel means fraction 0/1
	always_ff @(posedge clk) begin
		if (adv1 && acc && line) begin
			num_s1  <= seen_n ? dark_cnt_n : '0;
			den_s1  <= seen_n ? total_n : CW'(1);
			disc_s1 <= pix.disc_end;
		end
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	// stage 2 payload: num * 256 against threshold * den
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			lhs_s2       <= {num_s1, rlas_pkg::FRAC_Q'(0)};
			p_standby_s2 <= PW'(cfg.standby_fraction) * PW'(den_s1);
			p_work_s2    <= PW'(cfg.work_fraction) * PW'(den_s1);
			p_drive_s2   <= PW'(cfg.drive_fraction) * PW'(den_s1);
			disc_s2      <= disc_s1;
		end
	end

	// class from the compares, first failing threshold wins
	always_comb begin
		ev_data.disc = disc_s2;
		priority if (PW'(lhs_s2) < p_standby_s2) ev_data.cls = rlas_pkg::CLS_REST;
		else if (PW'(lhs_s2) < p_work_s2)        ev_data.cls = rlas_pkg::CLS_STANDBY;
		else if (PW'(lhs_s2) < p_drive_s2)       ev_data.cls = rlas_pkg::CLS_WORK;
		else                                     ev_data.cls = rlas_pkg::CLS_DRIVE;
	end

	assign ev_valid = v_s2;

endmodule

[rtl/core/rlas_evq.sv]
module rlas_evq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  rlas_pkg::rlas_evt_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output rlas_pkg::rlas_evt_t pop_data
);

	localparam int AW = rlas_pkg::EVQ_AW;
	localparam int DW = rlas_pkg::EVQ_AW + 1;

	rlas_pkg::rlas_evt_t mem_q [rlas_pkg::EVQ_DEPTH];
	logic [AW-1:0]       wr_q, rd_q;
	logic [DW-1:0]       cnt_q;
	logic                push, pop;

	assign push_ready = cnt_q != DW'(rlas_pkg::EVQ_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + AW'(1);
			if (pop)  rd_q <= rd_q + AW'(1);
			cnt_q <= cnt_q + DW'(push) - DW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

[rtl/core/rlas_back.sv]
module rlas_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [rlas_pkg::ANGLE_W-1:0]     short_run_limit,
	input  logic                             ev_valid,
	output logic                             ev_ready,
	input  rlas_pkg::rlas_evt_t              ev_data,
	rlas_seg_if.source                       seg
);

	localparam int AW       = rlas_pkg::ANGLE_W;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = OQ_AW + 1;
	// one line can close two runs and then end the disc
	localparam int MAX_SEGS = 3;

	function automatic rlas_pkg::rlas_seg_t make_seg(rlas_pkg::rlas_cls_t c,
		logic [AW-1:0] s, logic [AW-1:0] e, logic last);
		rlas_pkg::rlas_seg_t r;
		r.activity_class = c;
		r.start_sample   = s;
		r.end_sample     = e;
		r.duration       = e - s;
		r.last_segment   = last;
		return r;
	endfunction

	// run and open segment state
	logic [AW-1:0]       angle_q;
	rlas_pkg::rlas_cls_t run_cls_q;
	logic [AW-1:0]       run_start_q;
	logic                run_v_q;
	rlas_pkg::rlas_cls_t open_cls_q;
	logic [AW-1:0]       open_start_q;
	logic [AW-1:0]       open_end_q;
	logic                open_v_q;

	// next state
	logic [AW-1:0]       angle_n;
	rlas_pkg::rlas_cls_t run_cls_n;
	logic [AW-1:0]       run_start_n;
	logic                run_v_n;
	rlas_pkg::rlas_cls_t open_cls_n;
	logic [AW-1:0]       open_start_n;
	logic [AW-1:0]       open_end_n;
	logic                open_v_n;
	logic [AW-1:0]       len1, len2;

	rlas_pkg::rlas_seg_t res [MAX_SEGS];
	logic [MAX_SEGS-1:0] emit;

	// result queue
	rlas_pkg::rlas_seg_t oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0]    oq_wr_q, oq_rd_q;
	logic [OQ_CW-1:0]    oq_cnt_q;
	logic [OQ_AW-1:0]    wpos [MAX_SEGS];
	logic [OQ_AW-1:0]    n_emit;
	logic                take, give;

	// take a line only while the queue can hold its worst case
	assign ev_ready = oq_cnt_q <= OQ_CW'(OQ_DEPTH - MAX_SEGS);
	assign take     = ev_valid && ev_ready;
	assign give     = seg.valid && seg.ready;

	// segmentation of one classified line
	always_comb begin
		angle_n      = angle_q;
		run_cls_n    = run_cls_q;
		run_start_n  = run_start_q;
		run_v_n      = run_v_q;
		open_cls_n   = open_cls_q;
		open_start_n = open_start_q;
		open_end_n   = open_end_q;
		open_v_n     = open_v_q;
		emit         = '0;
		len1         = angle_q - run_start_q;
		len2         = '0;
		for (int k = 0; k < MAX_SEGS; k++) begin
			res[k] = make_seg(open_cls_q, open_start_q, open_end_q, 1'b0);
		end

		if (angle_q < AW'(rlas_pkg::SAMPLES_PER_TURN)) begin
			// class change closes the current run
			if (run_v_n && ev_data.cls != run_cls_n) begin
				if (open_v_n && (len1 <= short_run_limit || run_cls_n == open_cls_n)) begin
					open_end_n = open_end_n + len1;
				end else begin
					emit[0]      = open_v_n;
					res[0]       = make_seg(open_cls_n, open_start_n, open_end_n, 1'b0);
					open_cls_n   = run_cls_n;
					open_start_n = run_start_n;
					open_end_n   = angle_q;
					open_v_n     = 1'b1;
				end
				run_v_n = 1'b0;
			end
			if (!run_v_n) begin
				run_cls_n   = ev_data.cls;
				run_start_n = angle_q;
				run_v_n     = 1'b1;
			end
			angle_n = angle_q + AW'(1);
		end

		if (ev_data.disc) begin
			// final run closes, then the open segment goes out as last
			if (run_v_n) begin
				len2 = angle_n - run_start_n;
				if (open_v_n && (len2 <= short_run_limit || run_cls_n == open_cls_n)) begin
					open_end_n = open_end_n + len2;
				end else begin
					emit[1]      = open_v_n;
					res[1]       = make_seg(open_cls_n, open_start_n, open_end_n, 1'b0);
					open_cls_n   = run_cls_n;
					open_start_n = run_start_n;
					open_end_n   = angle_n;
					open_v_n     = 1'b1;
				end
			end
			emit[2]      = open_v_n;
			res[2]       = make_seg(open_cls_n, open_start_n, open_end_n, 1'b1);
			angle_n      = '0;
			run_cls_n    = rlas_pkg::CLS_REST;
			run_start_n  = '0;
			run_v_n      = 1'b0;
			open_cls_n   = rlas_pkg::CLS_REST;
			open_start_n = '0;
			open_end_n   = '0;
			open_v_n     = 1'b0;
		end
	end

	// packed write slots for the emitted segments
	always_comb begin
		n_emit = '0;
		for (int k = 0; k < MAX_SEGS; k++) begin
			wpos[k] = oq_wr_q + n_emit;
			n_emit  = n_emit + OQ_AW'(emit[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q      <= '0;
			run_cls_q    <= rlas_pkg::CLS_REST;
			run_start_q  <= '0;
			run_v_q      <= 1'b0;
			open_cls_q   <= rlas_pkg::CLS_REST;
			open_start_q <= '0;
			open_end_q   <= '0;
			open_v_q     <= 1'b0;
		end else if (take) begin
			angle_q      <= angle_n;
			run_cls_q    <= run_cls_n;
			run_start_q  <= run_start_n;
			run_v_q      <= run_v_n;
			open_cls_q   <= open_cls_n;
			open_start_q <= open_start_n;
			open_end_q   <= open_end_n;
			open_v_q     <= open_v_n;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (take) oq_wr_q <= oq_wr_q + n_emit;
			if (give) oq_rd_q <= oq_rd_q + OQ_AW'(1);
			oq_cnt_q <= oq_cnt_q + (take ? OQ_CW'(n_emit) : '0) - OQ_CW'(give);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_SEGS; k++) begin
			if (take && emit[k]) oq_q[wpos[k]] <= res[k];
		end
	end

	// output beat
	assign seg.valid          = oq_cnt_q != '0;
	assign seg.activity_class = oq_q[oq_rd_q].activity_class;
	assign seg.start_sample   = oq_q[oq_rd_q].start_sample;
	assign seg.end_sample     = oq_q[oq_rd_q].end_sample;
	assign seg.duration       = oq_q[oq_rd_q].duration;
	assign seg.last_segment   = oq_q[oq_rd_q].last_segment;

endmodule

[rtl/core/radial_line_activity_segmenter.sv]
// A segment caused by the pixel that ends a line passes two classify stages, the event
//   queue and the result queue on its way to seg.
// Throughput: one pixel per cycle while pix.ready is high; the segmenter takes one line
//   per cycle while its result queue can hold three more segments; results leave at one
//   per cycle while seg.ready is high. Reset (arst_n low): all counters, queues and run
//   state clear, registers take defaults; no clearing pass, pix.ready is high at once.
module radial_line_activity_segmenter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rlas_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [rlas_pkg::CFG_DATA_W-1:0]    cfg_data,
	rlas_pix_if.sink                           pix,
	rlas_seg_if.source                         seg
);

	rlas_pkg::rlas_cfg_t cfg_q;
	rlas_pkg::rlas_evt_t fr_data, bk_data;
	logic                fr_valid, fr_ready, bk_valid, bk_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_level       <= rlas_pkg::DARK_LEVEL_RST;
			cfg_q.standby_fraction <= rlas_pkg::STANDBY_RST;
			cfg_q.work_fraction    <= rlas_pkg::WORK_RST;
			cfg_q.drive_fraction   <= rlas_pkg::DRIVE_RST;
			cfg_q.short_run_limit  <= rlas_pkg::SHORT_RUN_RST;
		end else if (cfg_we) begin
			unique case (rlas_pkg::rlas_reg_t'(cfg_idx))
				rlas_pkg::REG_DARK_LEVEL:
					cfg_q.dark_level <= cfg_data[rlas_pkg::PIX_W-1:0];
				rlas_pkg::REG_STANDBY_FRACTION:
					cfg_q.standby_fraction <= cfg_data[rlas_pkg::FRAC_W-1:0];
				rlas_pkg::REG_WORK_FRACTION:
					cfg_q.work_fraction <= cfg_data[rlas_pkg::FRAC_W-1:0];
				rlas_pkg::REG_DRIVE_FRACTION:
					cfg_q.drive_fraction <= cfg_data[rlas_pkg::FRAC_W-1:0];
				rlas_pkg::REG_SHORT_RUN_LIMIT:
					cfg_q.short_run_limit <= cfg_data[rlas_pkg::ANGLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// pixel counting and line classification
	rlas_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pix      (pix),
		.ev_valid (fr_valid),
		.ev_ready (fr_ready),
		.ev_data  (fr_data)
	);

	// classified lines waiting for the segmenter
	rlas_evq u_evq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_data),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_data   (bk_data)
	);

	// run merging and segment output
	rlas_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.short_run_limit (cfg_q.short_run_limit),
		.ev_valid        (bk_valid),
		.ev_ready        (bk_ready),
		.ev_data         (bk_data),
		.seg             (seg)
	);

	// every segment spans at least one angle sample inside the turn
	a_seg_span: assert property (@(posedge clk) disable iff (!arst_n)
		seg.valid |-> (seg.end_sample > seg.start_sample) &&
			(seg.end_sample <= rlas_pkg::ANGLE_W'(rlas_pkg::SAMPLES_PER_TURN)))
		else $error("segment span out of range");

	// duration agrees with the segment bounds
	a_seg_dur: assert property (@(posedge clk) disable iff (!arst_n)
		seg.valid |-> seg.duration == rlas_pkg::ANGLE_W'(seg.end_sample - seg.start_sample))
		else $error("segment duration mismatch");

	// a line that meets a full event queue stays offered and is not dropped
	a_evq_room: assert property (@(posedge clk) disable iff (!arst_n)
		(fr_valid && !fr_ready) |=> fr_valid)
		else $error("classified line dropped");

endmodule

[tb/tb_radial_line_activity_segmenter.sv]
`timescale 1ns / 1ps

module tb_radial_line_activity_segmenter;
	import rlas_pkg::*;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic             line_end;
		logic             disc_end;
	} pixel_beat_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	rlas_pix_if pix ();
	rlas_seg_if seg ();

	radial_line_activity_segmenter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.pix      (pix),
		.seg      (seg)
	);

	// shadow of the config registers
	logic [PIX_W-1:0]   m_dark_level;
	logic [FRAC_W-1:0]  m_standby;
	logic [FRAC_W-1:0]  m_work;
	logic [FRAC_W-1:0]  m_drive;
	logic [ANGLE_W-1:0] m_short_limit;

	// line counters, current run, open segment
	logic [CNT_W-1:0]   line_dark;
	logic [CNT_W-1:0]   line_total;
	bit                 line_dark_seen;
	logic [ANGLE_W-1:0] angle;
	rlas_cls_t          run_cls;
	logic [ANGLE_W-1:0] run_first;
	bit                 run_open;
	rlas_cls_t          seg_cls;
	logic [ANGLE_W-1:0] seg_first;
	logic [ANGLE_W-1:0] seg_stop;
	bit                 seg_open;

	rlas_seg_t   segments_due[$];
	pixel_beat_t pixels_pending[$];
	pixel_beat_t beat_on_bus;

	int pushed_beats;
	int accepted_beats;
	int predicted_segs;
	int fail_count;
	int snd_idle_pct;
	int rcv_stall_pct;
	int hold_seq;
	int hold_seen;
	int hold_left;
	int long_lines_left;

	always #6 clk = ~clk;

	// ---------------- segment predictor ----------------

	function automatic void clear_prediction();
		m_dark_level   = DARK_LEVEL_RST;
		m_standby      = STANDBY_RST;
		m_work         = WORK_RST;
		m_drive        = DRIVE_RST;
		m_short_limit  = SHORT_RUN_RST;
		line_dark      = '0;
		line_total     = '0;
		line_dark_seen = 1'b0;
		angle          = '0;
		run_cls        = CLS_REST;
		run_first      = '0;
		run_open       = 1'b0;
		seg_cls        = CLS_REST;
		seg_first      = '0;
		seg_stop       = '0;
		seg_open       = 1'b0;
	endfunction

	// exact cross-product compare of the dark fraction with the Q8 thresholds
	function automatic rlas_cls_t line_class();
		longint num, den, lhs;
		num = line_dark_seen ? longint'(line_dark) : 0;
		den = line_dark_seen ? longint'(line_total) : 1;
		if (den == 0) begin
			num = 0;
			den = 1;
		end
		lhs = num * 256;
		if (lhs < longint'(m_standby) * den) return CLS_REST;
		if (lhs < longint'(m_work) * den) return CLS_STANDBY;
		if (lhs < longint'(m_drive) * den) return CLS_WORK;
		return CLS_DRIVE;
	endfunction

	function automatic void emit_segment(bit last);
		rlas_seg_t s;
		s.activity_class = seg_cls;
		s.start_sample   = seg_first;
		s.end_sample     = seg_stop;
		s.duration       = seg_stop - seg_first;
		s.last_segment   = last;
		segments_due     = {segments_due, s};
		predicted_segs++;
	endfunction

	// short or same-class runs extend the open segment, others replace it
	function automatic void close_run(logic [ANGLE_W-1:0] stop);
		logic [ANGLE_W-1:0] len;
		len = stop - run_first;
		if (seg_open && (len <= m_short_limit || run_cls == seg_cls)) begin
			seg_stop = seg_stop + len;
		end else begin
			if (seg_open) emit_segment(1'b0);
			seg_cls   = run_cls;
			seg_first = run_first;
			seg_stop  = stop;
			seg_open  = 1'b1;
		end
		run_open = 1'b0;
	endfunction

	function automatic void predict_pixel(pixel_beat_t b);
		bit        ends_line;
		rlas_cls_t cls;
		ends_line = b.line_end || b.disc_end;
		// pixels past the line cap are ignored
		if (line_total < MAX_LINE_PIXELS) begin
			if (b.pixel < m_dark_level) begin
				line_dark_seen = 1'b1;
				line_dark      = line_dark + CNT_W'(1);
			end
			if (line_dark_seen) line_total = line_total + CNT_W'(1);
		end
		if (ends_line) begin
			cls = line_class();
			// lines past a full turn are dropped
			if (angle < SAMPLES_PER_TURN) begin
				if (run_open && cls != run_cls) close_run(angle);
				if (!run_open) begin
					run_cls   = cls;
					run_first = angle;
					run_open  = 1'b1;
				end
				angle = angle + ANGLE_W'(1);
			end
			line_dark      = '0;
			line_total     = '0;
			line_dark_seen = 1'b0;
		end
		if (b.disc_end) begin
			if (run_open) close_run(angle);
			if (seg_open) emit_segment(1'b1);
			angle     = '0;
			run_cls   = CLS_REST;
			run_first = '0;
			run_open  = 1'b0;
			seg_cls   = CLS_REST;
			seg_first = '0;
			seg_stop  = '0;
			seg_open  = 1'b0;
		end
	endfunction

	// ---------------- pixel driver ----------------

	always @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			predict_pixel(beat_on_bus);
			accepted_beats++;
		end
		if (!pix.valid || pix.ready) begin
			if (arst_n && pixels_pending.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
				beat_on_bus  = pixels_pending.pop_front();
				pix.valid    <= 1'b1;
				pix.pixel    <= beat_on_bus.pixel;
				pix.line_end <= beat_on_bus.line_end;
				pix.disc_end <= beat_on_bus.disc_end;
			end else begin
				pix.valid <= 1'b0;
			end
		end
	end

	// ---------------- segment monitor ----------------

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : seg_mon
		rlas_seg_t want;
		if (arst_n && seg.valid && seg.ready) begin
			if (segments_due.size() == 0) begin
				$error("segment beat with nothing expected: class %0d start %0d end %0d",
					seg.activity_class, seg.start_sample, seg.end_sample);
				fail_count++;
			end else begin
				want = segments_due.pop_front();
				check_field("activity_class", want.activity_class, seg.activity_class);
				check_field("start_sample", want.start_sample, seg.start_sample);
				check_field("end_sample", want.end_sample, seg.end_sample);
				check_field("duration", want.duration, seg.duration);
				check_field("last_segment", want.last_segment, seg.last_segment);
			end
		end
		// long hold-off on request, otherwise random stalls
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			seg.ready <= 1'b0;
		end else begin
			seg.ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// ---------------- stimulus ----------------

	task automatic push_beat(int px, bit le, bit de);
		pixel_beat_t b;
		b.pixel        = PIX_W'(px);
		b.line_end     = le;
		b.disc_end     = de;
		pixels_pending = {pixels_pending, b};
		pushed_beats++;
	endtask

	task automatic write_reg(rlas_reg_t idx, int value);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= CFG_DATA_W'(value);
		case (idx)
			REG_DARK_LEVEL:       m_dark_level  = PIX_W'(value);
			REG_STANDBY_FRACTION: m_standby     = FRAC_W'(value);
			REG_WORK_FRACTION:    m_work        = FRAC_W'(value);
			REG_DRIVE_FRACTION:   m_drive       = FRAC_W'(value);
			REG_SHORT_RUN_LIMIT:  m_short_limit = ANGLE_W'(value);
			default: ;
		endcase
	endtask

	task automatic load_config(int dl, int st, int wk, int dr, int sr);
		write_reg(REG_DARK_LEVEL, dl);
		write_reg(REG_STANDBY_FRACTION, st);
		write_reg(REG_WORK_FRACTION, wk);
		write_reg(REG_DRIVE_FRACTION, dr);
		write_reg(REG_SHORT_RUN_LIMIT, sr);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_idle(int mode);
		case (mode)
			1: begin snd_idle_pct = 65; rcv_stall_pct = 0; end
			2: begin snd_idle_pct = 0; rcv_stall_pct = 65; end
			3: begin snd_idle_pct = 21; rcv_stall_pct = 21; end
			default: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
		endcase
	endtask

	// all beats taken, all segments seen, then room for lines still in flight
	task automatic drain();
		while (accepted_beats != pushed_beats || segments_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// mood is the percentage of dark pixels
	function automatic logic [PIX_W-1:0] pick_pixel(int mood, bit want_dark);
		if (!want_dark && $urandom_range(9) == 0) return PIX_W'($urandom_range(255));
		if (want_dark || $urandom_range(99) < mood) begin
			if (m_dark_level == 0) return PIX_W'($urandom_range(255));
			return PIX_W'($urandom_range(0, m_dark_level - 1));
		end
		return PIX_W'($urandom_range(m_dark_level, 255));
	endfunction

	task automatic gen_disc(int n_lines, int max_len);
		int mood, len;
		bit long_line, le, de;
		mood = $urandom_range(100);
		for (int l = 0; l < n_lines; l++) begin
			if ($urandom_range(3) == 0) mood = $urandom_range(100);
			long_line = long_lines_left > 0 && $urandom_range(19) == 0;
			if (long_line) begin
				long_lines_left--;
				len = $urandom_range(257, 300);
			end else begin
				len = $urandom_range(1, max_len);
			end
			for (int k = 0; k < len; k++) begin
				le = (k == len - 1);
				de = le && (l == n_lines - 1);
				// disc end may come with or without its line end flag
				if (de) le = 1'($urandom_range(1));
				push_beat(pick_pixel(mood, long_line && k == 0), le, de);
			end
		end
	endtask

	// hand-picked discs at reset settings
	task automatic directed_discs();
		// classes 3, 0, 2, 1, 3: all short runs fold into one segment
		push_beat(0, 1, 0);
		push_beat(255, 1, 0);
		push_beat(255, 0, 0);
		push_beat(0, 0, 0);
		push_beat(255, 1, 0);
		push_beat(0, 0, 0);
		push_beat(200, 0, 0);
		push_beat(200, 1, 0);
		push_beat(127, 0, 1);
		// one-line disc, pixel right at the dark level
		push_beat(128, 1, 1);
		// long class-3 run then long class-0 run: two segments on one beat
		repeat (4) push_beat(0, 1, 0);
		repeat (4) push_beat(255, 1, 0);
		push_beat(255, 1, 1);
		// disc with no dark pixel and no line end flag
		push_beat(255, 0, 0);
		push_beat(255, 0, 1);
	endtask

	initial begin
		int st, wk, dr, sr, base;
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = '0;
		cfg_data     = '0;
		pix.valid    = 1'b0;
		pix.pixel    = '0;
		pix.line_end = 1'b0;
		pix.disc_end = 1'b0;
		seg.ready    = 1'b0;
		pushed_beats    = 0;
		accepted_beats  = 0;
		predicted_segs  = 0;
		fail_count      = 0;
		hold_seq        = 0;
		hold_seen       = 0;
		hold_left       = 0;
		long_lines_left = 1;
		set_idle(0);
		clear_prediction();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < 8; p++) begin
			drain();
			case (p)
				0: ;
				1: load_config(0, 0, 0, 0, 0);
				2: load_config(255, 256, 256, 256, 1440);
				// drive threshold beyond full scale: class 3 never reached
				3: load_config(128, 32, 100, 300, 1);
				default: begin
					st = $urandom_range(128);
					wk = st + $urandom_range(64);
					dr = wk + $urandom_range(64);
					sr = ($urandom_range(3) == 0) ? $urandom_range(1440) : $urandom_range(5);
					load_config($urandom_range(255), st, wk, dr, sr);
				end
			endcase
			set_idle(p % 4);
			if (p == 0) directed_discs();
			// one-line discs, one segment each: enough to back up every queue
			if (p == 4) repeat (12) push_beat(0, 1, 1);
			base = pushed_beats;
			while (pushed_beats - base < 20) gen_disc($urandom_range(1, 8), 5);
			// sink holds off while pixels keep coming
			if (p == 4) hold_seq++;
		end

		// more lines than a turn holds: the extra ones are dropped
		drain();
		load_config(128, 64, 128, 192, 2);
		set_idle(1);
		gen_disc(1442, 1);
		drain();

		set_idle(0);
		while (predicted_segs < 48) begin
			gen_disc($urandom_range(10, 40), 4);
			drain();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
